// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the stripper RTL.
// No dependencies; included by the controller and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is low.
`define LSES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a condition never holds on the rising clock edge.
`define LSES_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/lses_pkg.sv -----
// Package of the leading space entab stripper: byte codes and the
// command and status structs between controller and datapath. No dependencies.
package lses_pkg;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'd32;

  typedef struct packed {
    logic load;
    logic lead_adv;
    logic lead_start;
    logic push;
    logic spill;
    logic emit_tab;
    logic emit_sp;
    logic emit_mark;
    logic emit_final;
  } lses_cmd_t;

  typedef struct packed {
    logic is_end;
    logic is_eol;
    logic is_ws;
    logic in_leading;
    logic tab_zero;
    logic sp_zero;
    logic pend_zero;
    logic pend_full;
    logic out_free;
  } lses_sts_t;

endpackage

// ----- hw/rtl/lses_in_if.sv -----
// Input channel of the stripper: one text byte per transaction.
// No dependencies.
interface lses_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// ----- hw/rtl/lses_out_if.sv -----
// Output channel of the stripper: one emitted byte and its flags per transaction.
// No dependencies.
interface lses_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch;
  logic       last_of_run;
  logic       end_of_text;
  logic       overflow;

  modport source (output valid, output out_ch, output last_of_run,
                  output end_of_text, output overflow, input ready);
  modport sink (input valid, input out_ch, input last_of_run,
                input end_of_text, input overflow, output ready);
endinterface

// ----- hw/rtl/lses_ctrl.sv -----
// Sequencer of the stripper: decodes each byte and steps the datapath
// through its emission phases. Depends on lses_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lses_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lses_pkg::lses_sts_t sts_i,
  output lses_pkg::lses_cmd_t cmd_o
);
  import lses_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_LTAB   = 3'd2;
  localparam logic [2:0] S_LSP    = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_SPILL  = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;

  logic [2:0] state_q, state_d;
  lses_cmd_t  cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_end || sts_i.is_eol) begin
          state_d = S_FINAL;
        end else if (sts_i.in_leading && sts_i.is_ws) begin
          cmd.lead_adv = 1'b1;
          state_d      = S_IDLE;
        end else if (sts_i.in_leading) begin
          cmd.lead_start = 1'b1;
          state_d        = S_LTAB;
        end else if (sts_i.is_ws && sts_i.pend_full) begin
          state_d = S_SPILL;
        end else if (sts_i.is_ws) begin
          cmd.push = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_LTAB: begin
        if (sts_i.tab_zero) begin
          state_d = S_LSP;
        end else if (sts_i.out_free) begin
          cmd.emit_tab = 1'b1;
        end
      end
      S_LSP: begin
        if (sts_i.sp_zero) begin
          state_d = S_FINAL;
        end else if (sts_i.out_free) begin
          cmd.emit_sp = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts_i.pend_zero) begin
          state_d = S_FINAL;
        end else if (sts_i.out_free) begin
          cmd.emit_mark = 1'b1;
        end
      end
      S_SPILL: begin
        if (sts_i.out_free) begin
          cmd.spill = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd.emit_final = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LSES_ASSERT(a_load_decodes, clk_i, rst_ni, cmd.load |=> (state_q == S_DECODE),
               "accepted byte not decoded next cycle")
  `LSES_ASSERT(a_final_done, clk_i, rst_ni, cmd.emit_final |=> (state_q == S_IDLE && in_ready_o),
               "channel not reopened after final result")
  `LSES_NEVER(a_ws_lead_emits, clk_i, rst_ni,
              (state_q == S_DECODE) && sts_i.in_leading && sts_i.is_ws &&
              !sts_i.is_end && !sts_i.is_eol && (state_d != S_IDLE),
              "leading whitespace must not start an emission")
endmodule

// ----- hw/rtl/lses_dp.sv -----
// Datapath of the stripper: byte latch, leading column, pending mark run,
// overflow flag and the output register. Depends on lses_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lses_dp #(
  parameter int LEAD_COL_MAX = 120,
  parameter int PENDING_MAX  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          ch_i,
  input  lses_pkg::lses_cmd_t cmd_i,
  output lses_pkg::lses_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_ch_o,
  output logic                last_of_run_o,
  output logic                end_of_text_o,
  output logic                overflow_o
);
  import lses_pkg::*;

  localparam int LCW = $clog2(LEAD_COL_MAX + 1);
  localparam int TCW = LCW - 2;
  localparam int PCW = $clog2(PENDING_MAX + 1);

  logic [7:0]             ch_q, ch_d;
  logic                   lead_q, lead_d;
  logic [LCW-1:0]         col_q, col_d;
  logic [TCW-1:0]         tab_cnt_q, tab_cnt_d;
  logic [1:0]             sp_cnt_q, sp_cnt_d;
  logic [PCW-1:0]         pend_cnt_q, pend_cnt_d;
  logic [PENDING_MAX-1:0] pend_tab_q, pend_tab_d;
  logic                   ovf_q, ovf_d;
  logic                   ov_q, ov_d;
  logic [7:0]             o_ch_q, o_ch_d;
  logic                   o_last_q, o_last_d;
  logic                   o_eot_q, o_eot_d;
  logic                   o_ovf_q, o_ovf_d;

  logic                   is_tab, is_end, is_eol, out_free, emit_any;
  logic [LCW:0]           col_ext, col_nxt;
  logic [PENDING_MAX-1:0] push_oh;
  logic [7:0]             mark_ch;

  assign is_tab   = (ch_q == CH_TAB);
  assign is_end   = (ch_q == CH_NUL);
  assign is_eol   = (ch_q == CH_LF) || (ch_q == CH_CR);
  assign out_free = !ov_q || out_ready_i;
  assign emit_any = cmd_i.emit_tab || cmd_i.emit_sp || cmd_i.emit_mark ||
                    cmd_i.spill || cmd_i.emit_final;
  assign col_ext  = {1'b0, col_q};
  assign col_nxt  = is_tab ? ((col_ext | (LCW+1)'(3)) + (LCW+1)'(1))
                           : (col_ext + (LCW+1)'(1));
  assign push_oh  = PENDING_MAX'(1) << pend_cnt_q;
  assign mark_ch  = pend_tab_q[0] ? CH_TAB : CH_SP;

  always_comb begin
    sts_o.is_end     = is_end;
    sts_o.is_eol     = is_eol;
    sts_o.is_ws      = is_tab || (ch_q == CH_SP);
    sts_o.in_leading = lead_q;
    sts_o.tab_zero   = (tab_cnt_q == '0);
    sts_o.sp_zero    = (sp_cnt_q == '0);
    sts_o.pend_zero  = (pend_cnt_q == '0);
    sts_o.pend_full  = (pend_cnt_q >= PCW'(PENDING_MAX));
    sts_o.out_free   = out_free;
  end

  always_comb begin
    ch_d       = ch_q;
    lead_d     = lead_q;
    col_d      = col_q;
    tab_cnt_d  = tab_cnt_q;
    sp_cnt_d   = sp_cnt_q;
    pend_cnt_d = pend_cnt_q;
    pend_tab_d = pend_tab_q;
    ovf_d      = ovf_q;
    ov_d       = ov_q && !out_ready_i;
    o_ch_d     = o_ch_q;
    o_last_d   = o_last_q;
    o_eot_d    = o_eot_q;
    o_ovf_d    = o_ovf_q;

    if (cmd_i.load) begin
      ch_d = ch_i;
    end
    if (cmd_i.lead_adv) begin
      if (col_nxt > (LCW+1)'(LEAD_COL_MAX)) begin
        col_d = LCW'(LEAD_COL_MAX);
        ovf_d = 1'b1;
      end else begin
        col_d = col_nxt[LCW-1:0];
      end
    end
    if (cmd_i.lead_start) begin
      tab_cnt_d = col_q[LCW-1:2];
      sp_cnt_d  = col_q[1:0];
      col_d     = '0;
      lead_d    = 1'b0;
    end
    if (cmd_i.push) begin
      pend_tab_d = is_tab ? (pend_tab_q | push_oh) : (pend_tab_q & ~push_oh);
      pend_cnt_d = pend_cnt_q + PCW'(1);
    end
    if (emit_any) begin
      ov_d     = 1'b1;
      o_last_d = 1'b0;
      o_eot_d  = 1'b0;
      o_ovf_d  = ovf_q;
    end
    if (cmd_i.emit_tab) begin
      o_ch_d    = CH_TAB;
      tab_cnt_d = tab_cnt_q - TCW'(1);
    end
    if (cmd_i.emit_sp) begin
      o_ch_d   = CH_SP;
      sp_cnt_d = sp_cnt_q - 2'd1;
    end
    if (cmd_i.emit_mark) begin
      o_ch_d     = mark_ch;
      pend_tab_d = pend_tab_q >> 1;
      pend_cnt_d = pend_cnt_q - PCW'(1);
    end
    if (cmd_i.spill) begin
      o_ch_d     = mark_ch;
      o_last_d   = 1'b1;
      o_ovf_d    = 1'b1;
      ovf_d      = 1'b1;
      pend_tab_d = {is_tab, pend_tab_q[PENDING_MAX-1:1]};
    end
    if (cmd_i.emit_final) begin
      o_ch_d   = ch_q;
      o_last_d = 1'b1;
      o_eot_d  = is_end;
      if (is_end || is_eol) begin
        lead_d     = 1'b1;
        col_d      = '0;
        pend_cnt_d = '0;
        ovf_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q     <= 1'b1;
      col_q      <= '0;
      tab_cnt_q  <= '0;
      sp_cnt_q   <= '0;
      pend_cnt_q <= '0;
      ovf_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      lead_q     <= lead_d;
      col_q      <= col_d;
      tab_cnt_q  <= tab_cnt_d;
      sp_cnt_q   <= sp_cnt_d;
      pend_cnt_q <= pend_cnt_d;
      ovf_q      <= ovf_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    pend_tab_q <= pend_tab_d;
    o_ch_q     <= o_ch_d;
    o_last_q   <= o_last_d;
    o_eot_q    <= o_eot_d;
    o_ovf_q    <= o_ovf_d;
  end

  assign out_valid_o   = ov_q;
  assign out_ch_o      = o_ch_q;
  assign last_of_run_o = o_last_q;
  assign end_of_text_o = o_eot_q;
  assign overflow_o    = o_ovf_q;

  `LSES_NEVER(a_emit_busy, clk_i, rst_ni, emit_any && ov_q && !out_ready_i,
              "result issued while output register is held")
  `LSES_NEVER(a_pend_bound, clk_i, rst_ni, pend_cnt_q > PCW'(PENDING_MAX),
              "pending run beyond its bound")
  `LSES_ASSERT(a_line_restart, clk_i, rst_ni,
               (cmd_i.emit_final && (is_end || is_eol)) |=>
               (lead_q && (pend_cnt_q == '0) && (col_q == '0) && !ovf_q),
               "line state not restarted after terminator")
endmodule

// ----- hw/rtl/leading_space_entab_stripper.sv -----
// Top level of the leading space entab stripper.
// Depends on lses_pkg, lses_in_if, lses_out_if, lses_ctrl and lses_dp.
//
// Usage:
//   in_i carries one text byte per transaction; out_o carries one emitted
//   byte per transaction with last_of_run, end_of_text and overflow flags.
//   Leading spaces and tabs are re-emitted as col/4 tabs and col%4 spaces
//   ahead of the first other byte; later whitespace is held and flushed
//   ahead of the next other byte, or dropped at CR, LF or a zero byte.
//   A zero byte yields one terminator result with end_of_text set.
// Sequencing: whitespace that is only absorbed yields no result; CR, LF,
//   a zero byte or a pending-run spill yields one result. The sequencer
//   decodes one byte and then steps through its emission phases (leading
//   tabs, leading spaces, pending marks, spill, final byte), emitting one
//   result per cycle within a phase while the output register is free,
//   through a single output register; the next byte is taken once the
//   last result has entered that register.
// Reset: the block starts at line start with no pending run and no
//   overflow; the output register is empty.
// Stall: a held output register stops the sequencer; no result is lost.
module leading_space_entab_stripper #(
  parameter int LEAD_COL_MAX = 120,
  parameter int PENDING_MAX  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lses_in_if.sink    in_i,
  lses_out_if.source out_o
);
  import lses_pkg::*;

  lses_cmd_t cmd;
  lses_sts_t sts;

  lses_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lses_dp #(
    .LEAD_COL_MAX (LEAD_COL_MAX),
    .PENDING_MAX  (PENDING_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ch_i          (in_i.ch),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_ch_o      (out_o.out_ch),
    .last_of_run_o (out_o.last_of_run),
    .end_of_text_o (out_o.end_of_text),
    .overflow_o    (out_o.overflow)
  );
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench of leading_space_entab_stripper: directed, bound, stall and random text tests.
// Depends on lses_pkg, lses_in_if, lses_out_if and the stripper RTL.
module testbench;
  import lses_pkg::*;

  localparam int LEAD_COL_MAX = 120;
  localparam int PENDING_MAX  = 32;
  localparam int TAB_WIDTH    = 4;
  localparam int RANDOM_ITEMS = 150;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    logic [7:0] out_ch;
    logic       last_of_run;
    logic       end_of_text;
    logic       overflow;
  } entab_out_t;

  logic clk_i;
  logic rst_ni;

  lses_in_if  in_if ();
  lses_out_if out_if ();

  leading_space_entab_stripper #(
    .LEAD_COL_MAX(LEAD_COL_MAX),
    .PENDING_MAX (PENDING_MAX)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  entab_out_t entab_out_q[$];
  int mismatches = 0;
  int items_sent = 0;
  int src_calm = 0;
  int hold_requests = 0;
  int holds_served = 0;

  bit                   lead_active = 1'b1;
  int                   lead_col = 0;
  int                   pend_cnt = 0;
  logic [PENDING_MAX-1:0] pend_marks = '0;
  bit                   line_ovf = 1'b0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void restart_line();
    lead_active = 1'b1;
    lead_col    = 0;
    pend_cnt    = 0;
    pend_marks  = '0;
    line_ovf    = 1'b0;
  endfunction

  function automatic void emit_byte(input logic [7:0] c, input logic eot);
    entab_out_t r;
    r.out_ch      = c;
    r.last_of_run = 1'b0;
    r.end_of_text = eot;
    r.overflow    = line_ovf;
    entab_out_q.push_back(r);
  endfunction

  function automatic void predict_entab(input logic [7:0] c);
    int  start_size;
    int  next_col;
    bit  is_ws;
    start_size = entab_out_q.size();
    is_ws = (c == CH_SP) || (c == CH_TAB);
    if (c == CH_NUL) begin
      emit_byte(CH_NUL, 1'b1);
      restart_line();
    end else if (c == CH_LF || c == CH_CR) begin
      emit_byte(c, 1'b0);
      restart_line();
    end else if (lead_active) begin
      if (is_ws) begin
        next_col = (c == CH_SP) ? lead_col + 1 : (lead_col / TAB_WIDTH + 1) * TAB_WIDTH;
        if (next_col > LEAD_COL_MAX) begin
          next_col = LEAD_COL_MAX;
          line_ovf = 1'b1;
        end
        lead_col = next_col;
      end else begin
        repeat (lead_col / TAB_WIDTH) emit_byte(CH_TAB, 1'b0);
        repeat (lead_col % TAB_WIDTH) emit_byte(CH_SP, 1'b0);
        emit_byte(c, 1'b0);
        lead_active = 1'b0;
        lead_col    = 0;
      end
    end else if (is_ws) begin
      if (pend_cnt >= PENDING_MAX) begin
        line_ovf = 1'b1;
        emit_byte(pend_marks[0] ? CH_TAB : CH_SP, 1'b0);
        pend_marks = pend_marks >> 1;
        pend_cnt   = PENDING_MAX - 1;
      end
      pend_marks[pend_cnt] = (c == CH_TAB);
      pend_cnt++;
    end else begin
      for (int k = 0; k < pend_cnt; k++) emit_byte(pend_marks[k] ? CH_TAB : CH_SP, 1'b0);
      pend_cnt   = 0;
      pend_marks = '0;
      emit_byte(c, 1'b0);
    end
    if (entab_out_q.size() > start_size) entab_out_q[$].last_of_run = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = draw_gap(src_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    do @(posedge clk_i); while (!in_if.ready);
    predict_entab(c);
    items_sent++;
  endtask

  function automatic logic [7:0] ws_byte();
    return $urandom_range(0, 1) ? CH_TAB : CH_SP;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic send_ws_run(input int n);
    repeat (n) send_byte(ws_byte());
  endtask

  task automatic send_random_line();
    int r;
    int words;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_ws_run(($urandom_range(0, 19) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 9));
    words = $urandom_range(0, 5);
    for (int w = 0; w < words; w++) begin
      repeat ($urandom_range(1, 6)) send_byte(text_byte());
      if (w < words - 1 || $urandom_range(0, 3) == 0)
        send_ws_run(($urandom_range(0, 19) == 0) ? $urandom_range(30, 36)
                                                 : $urandom_range(1, 4));
    end
    r = $urandom_range(0, 99);
    if (r < 45) send_byte(CH_LF);
    else if (r < 80) send_byte(CH_CR);
    else if (r < 95) send_byte(CH_NUL);
  endtask

  task automatic test_directed();
    send_byte(8'h41);
    send_byte(CH_LF);
    send_byte(CH_SP);
    send_byte(CH_TAB);
    send_byte(CH_SP);
    send_byte(8'h62);
    send_byte(CH_SP);
    send_byte(CH_TAB);
    send_byte(8'h64);
    send_byte(CH_SP);
    send_byte(CH_SP);
    send_byte(CH_CR);
    send_byte(CH_TAB);
    send_byte(CH_SP);
    send_byte(CH_LF);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_SP);
    send_byte(CH_NUL);
    send_byte(CH_TAB);
    send_byte(CH_NUL);
    send_byte(CH_NUL);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(CH_LF);
  endtask

  task automatic test_bounds();
    repeat (LEAD_COL_MAX / TAB_WIDTH + 1) send_byte(CH_TAB);
    repeat (3) send_byte(CH_SP);
    send_byte(8'h78);
    send_byte(CH_LF);
    send_byte(8'h79);
    send_ws_run(PENDING_MAX + 8);
    send_byte(8'h7A);
    send_ws_run(PENDING_MAX + 3);
    send_byte(CH_LF);
    send_byte(8'h77);
    send_ws_run(PENDING_MAX + 2);
    send_byte(CH_NUL);
  endtask

  task automatic test_backpressure();
    hold_requests++;
    send_byte(CH_TAB);
    send_byte(CH_TAB);
    repeat (10) send_byte(text_byte());
    send_ws_run(6);
    repeat (20) send_byte(text_byte());
    send_byte(CH_LF);
  endtask

  task automatic test_random_text();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) send_random_line();
  endtask

  initial begin : sink_driver
    int hold;
    int calm;
    out_if.ready = 1'b0;
    hold = 0;
    calm = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        hold = draw_gap(calm);
      end
    end
  end

  always @(posedge clk_i) begin
    entab_out_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (entab_out_q.size() == 0) begin
        $error("out_ch %0d arrived with nothing expected", out_if.out_ch);
        mismatches++;
      end else begin
        exp_r = entab_out_q.pop_front();
        if (out_if.out_ch !== exp_r.out_ch) begin
          $error("out_ch: expected %0d, actual %0d", exp_r.out_ch, out_if.out_ch);
          mismatches++;
        end
        if (out_if.last_of_run !== exp_r.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b", exp_r.last_of_run,
                 out_if.last_of_run);
          mismatches++;
        end
        if (out_if.end_of_text !== exp_r.end_of_text) begin
          $error("end_of_text: expected %0b, actual %0b", exp_r.end_of_text,
                 out_if.end_of_text);
          mismatches++;
        end
        if (out_if.overflow !== exp_r.overflow) begin
          $error("overflow: expected %0b, actual %0b", exp_r.overflow, out_if.overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.ch    = CH_NUL;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_bounds();
    test_backpressure();
    test_random_text();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (entab_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && entab_out_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
